// ===== rtl/oci_pkg.sv =====
package oci_pkg;

  // Field widths of the stream items
  localparam int OP_W    = 2;
  localparam int COORD_W = 7;
  localparam int PROB_W  = 8;
  localparam int CVAL_W  = 16;
  localparam int OUT_W   = 16;

  // Input tdata layout, lowest bit first: row, col, probability, cost_value
  localparam int ROW_LSB   = 0;
  localparam int COL_LSB   = ROW_LSB + COORD_W;
  localparam int PROB_LSB  = COL_LSB + COORD_W;
  localparam int CVAL_LSB  = PROB_LSB + PROB_W;
  localparam int IN_BITS   = CVAL_LSB + CVAL_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Configuration register widths
  localparam int DIMREG_W   = 8;
  localparam int MAXCOST_W  = 16;
  localparam int STRENGTH_W = 16;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [DIMREG_W-1:0]   GRID_ROWS_RST = 8'd100;
  localparam logic [DIMREG_W-1:0]   GRID_COLS_RST = 8'd100;
  localparam logic [MAXCOST_W-1:0]  WALL_COST_RST = 16'd1000;
  localparam logic [STRENGTH_W-1:0] STRENGTH_RST  = 16'd40;
  localparam logic [THR_W-1:0]      FREE_THR_RST  = 8'd128;
  localparam logic [THR_W-1:0]      OCC_THR_RST   = 8'd204;

  // Cost every cell holds after reset
  localparam int RESET_COST = 2;

  // Parameter defaults
  localparam int GRID_DIM_DEF       = 128;
  localparam int INFLATE_RADIUS_DEF = 2;
  localparam int COST_BITS_DEF      = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_COST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_THR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_THR   = 3'd5;

  // Operation codes; the unused code acts as a read
  localparam logic [OP_W-1:0] OP_PROCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;

  // Reciprocal divide: floor(s/d) == (s * recip(d)) >> RECIP_SHIFT for 16-bit s, d <= 8
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;
  localparam int DIST_IDX_W  = 4;
  localparam int PROD_W      = STRENGTH_W + RECIP_W;

  function automatic logic [RECIP_W-1:0] recip(input logic [DIST_IDX_W-1:0] d);
    logic [RECIP_W-1:0] m;
    case (d)
      4'd1:    m = 21'd1048576;
      4'd2:    m = 21'd524288;
      4'd3:    m = 21'd349526;
      4'd4:    m = 21'd262144;
      4'd5:    m = 21'd209716;
      4'd6:    m = 21'd174763;
      4'd7:    m = 21'd149797;
      4'd8:    m = 21'd131072;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/occupancy_cost_inflation.sv =====
// Grid cost map with obstacle inflation. Items arrive on the s_ stream (operation in
// s_tuser) and each produces exactly one result on the m_ stream: the cell's cost after
// the item in m_tdata, out_of_range in m_tuser (cost reads as zero then). Items are
// handled one at a time. After reset the block sweeps the whole map to cost two, one
// cell a cycle, while s_tready stays low; configuration writes are taken at any time and
// should be made only while the block is idle. Out-of-range, write, unsure or wall-free
// items go straight to the finishing step, reads and free cells first do one cost
// memory read, and an occupied cell walks the inflation square one cell per cycle
// through a three-stage read-modify-write pipe on the single memory read/write port
// pair, skipping neighbors outside the grid, then drains the pipe. A finished result
// waits in the output register, so the next item is accepted while it is pending.
module occupancy_cost_inflation #(
  parameter int GRID_DIM       = oci_pkg::GRID_DIM_DEF,
  parameter int INFLATE_RADIUS = oci_pkg::INFLATE_RADIUS_DEF,
  parameter int COST_BITS      = oci_pkg::COST_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [oci_pkg::S_TDATA_W-1:0]   s_tdata,   // row, col, probability, cost_value, pad
  input  logic [oci_pkg::OP_W-1:0]        s_tuser,   // operation
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [oci_pkg::OUT_W-1:0]       m_tdata,   // cell_cost
  output logic                            m_tuser,   // out_of_range
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [oci_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [oci_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DIM_W   = $clog2(GRID_DIM);
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int CNT_W   = (DIM_W + 1 > 8) ? DIM_W + 1 : 8;
  localparam int OFF_W   = $clog2(2 * INFLATE_RADIUS + 1);
  localparam int RPLUS_W = DIM_W + 1;

  localparam logic [OFF_W-1:0]   OFF_LAST = OFF_W'(2 * INFLATE_RADIUS);
  localparam logic [OFF_W-1:0]   OFF_MID  = OFF_W'(INFLATE_RADIUS);
  localparam logic [RPLUS_W-1:0] RAD_EXT  = RPLUS_W'(INFLATE_RADIUS);
  localparam logic [CNT_W-1:0]   DIM_CAP  = CNT_W'(GRID_DIM);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_RDWAIT = 6'b000100,
    ST_SWEEP  = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;

  // configuration registers
  logic [oci_pkg::DIMREG_W-1:0]   grid_rows, grid_cols;
  logic [oci_pkg::MAXCOST_W-1:0]  wall_cost;
  logic [oci_pkg::STRENGTH_W-1:0] inflation_strength;
  logic [oci_pkg::THR_W-1:0]      free_threshold, occupied_threshold;

  // cost memory
  logic [COST_BITS-1:0] mem [DEPTH];
  logic                 rd_en, wr_en;
  logic [ADDR_W-1:0]    rd_addr, wr_addr;
  logic [COST_BITS-1:0] rd_data, wr_data;

  logic [ADDR_W-1:0] clr_cnt;

  // input field decode
  logic [oci_pkg::COORD_W-1:0] in_row, in_col;
  logic [oci_pkg::PROB_W-1:0]  in_prob;
  logic [oci_pkg::CVAL_W-1:0]  in_cval;
  logic [DIM_W-1:0]            in_row_d, in_col_d;
  logic [ADDR_W-1:0]           in_addr;
  logic                        acc, in_range, is_free, is_occ;
  logic [CNT_W-1:0]            rows_used, cols_used;
  logic [COST_BITS-1:0]        val_write, val_wall, val_half;
  logic [oci_pkg::OUT_W-1:0]   acc_cost;

  // center of the inflation square
  logic [DIM_W-1:0]  ctr_row, ctr_col;
  logic [ADDR_W-1:0] ctr_addr;

  // sweep position and neighbor decode
  logic [OFF_W-1:0]   sw_dr, sw_dc;
  logic [RPLUS_W-1:0] r_plus, c_plus, r_minus, c_minus;
  logic [OFF_W-1:0]   abs_dr, abs_dc, nb_dist;
  logic               nb_ok;
  logic [ADDR_W-1:0]  nb_addr;

  // read-modify-write pipe
  logic                         p1_valid, p2_valid;
  logic [ADDR_W-1:0]            p1_addr, p2_addr;
  logic [oci_pkg::PROD_W-1:0]   p1_prod;
  logic [oci_pkg::MAXCOST_W-1:0] p1_quot, p1_val;
  logic [COST_BITS-1:0]         p2_val, p2_old;

  logic                       res_oor;
  logic [oci_pkg::OUT_W-1:0]  res_cost;
  logic                       out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign acc       = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign in_row  = s_tdata[oci_pkg::ROW_LSB  +: oci_pkg::COORD_W];
  assign in_col  = s_tdata[oci_pkg::COL_LSB  +: oci_pkg::COORD_W];
  assign in_prob = s_tdata[oci_pkg::PROB_LSB +: oci_pkg::PROB_W];
  assign in_cval = s_tdata[oci_pkg::CVAL_LSB +: oci_pkg::CVAL_W];

  // grid size clamped to storage
  assign rows_used = (CNT_W'(grid_rows) > DIM_CAP) ? DIM_CAP : CNT_W'(grid_rows);
  assign cols_used = (CNT_W'(grid_cols) > DIM_CAP) ? DIM_CAP : CNT_W'(grid_cols);

  assign in_range = (CNT_W'(in_row) < rows_used) && (CNT_W'(in_col) < cols_used);
  assign in_row_d = DIM_W'(in_row);
  assign in_col_d = DIM_W'(in_col);
  assign in_addr  = {in_row_d, in_col_d};
  assign is_free  = in_prob <= free_threshold;
  assign is_occ   = in_prob > occupied_threshold;

  assign val_write = COST_BITS'(in_cval);
  assign val_wall  = COST_BITS'(wall_cost);
  assign val_half  = COST_BITS'(wall_cost >> 1);

  // result known at accept time (reads and free cells fill it in during the read-wait step)
  always_comb begin
    acc_cost = '0;
    if (in_range) begin
      case (s_tuser)
        oci_pkg::OP_WRITE: acc_cost = oci_pkg::OUT_W'(val_write);
        oci_pkg::OP_PROCESS: begin
          if (!is_free && is_occ) begin
            acc_cost = oci_pkg::OUT_W'(val_wall);
          end else if (!is_free) begin
            acc_cost = oci_pkg::OUT_W'(val_half);
          end
        end
        default: acc_cost = '0;
      endcase
    end
  end

  // neighbor coordinates from the sweep offsets
  assign ctr_addr = {ctr_row, ctr_col};
  assign r_plus   = RPLUS_W'(ctr_row) + RPLUS_W'(sw_dr);
  assign c_plus   = RPLUS_W'(ctr_col) + RPLUS_W'(sw_dc);
  assign r_minus  = r_plus - RAD_EXT;
  assign c_minus  = c_plus - RAD_EXT;
  assign abs_dr   = (sw_dr >= OFF_MID) ? sw_dr - OFF_MID : OFF_MID - sw_dr;
  assign abs_dc   = (sw_dc >= OFF_MID) ? sw_dc - OFF_MID : OFF_MID - sw_dc;
  assign nb_dist  = abs_dr + abs_dc;
  assign nb_addr  = {DIM_W'(r_minus), DIM_W'(c_minus)};
  assign nb_ok    = (state == ST_SWEEP)
                    && !(sw_dr == OFF_MID && sw_dc == OFF_MID)
                    && (r_plus >= RAD_EXT) && (CNT_W'(r_minus) < rows_used)
                    && (c_plus >= RAD_EXT) && (CNT_W'(c_minus) < cols_used);

  // inflation value: quotient capped at the wall cost
  assign p1_quot = p1_prod[oci_pkg::RECIP_SHIFT +: oci_pkg::MAXCOST_W];
  assign p1_val  = (p1_quot > wall_cost) ? wall_cost : p1_quot;

  // memory read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_addr;
    if (acc) begin
      rd_en = 1'b1;
    end else if (nb_ok) begin
      rd_en   = 1'b1;
      rd_addr = nb_addr;
    end
  end

  // memory write port: clearing pass, center update, or inflation write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = in_addr;
    wr_data = val_write;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = COST_BITS'(oci_pkg::RESET_COST);
    end else if (acc && in_range && s_tuser == oci_pkg::OP_WRITE) begin
      wr_en = 1'b1;
    end else if (acc && in_range && s_tuser == oci_pkg::OP_PROCESS && !is_free) begin
      wr_en   = 1'b1;
      wr_data = is_occ ? val_wall : val_half;
    end else if (p2_valid && p2_val > p2_old) begin
      wr_en   = 1'b1;
      wr_addr = p2_addr;
      wr_data = p2_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_CLEAR;
      clr_cnt            <= '0;
      sw_dr              <= '0;
      sw_dc              <= '0;
      p1_valid           <= 1'b0;
      p2_valid           <= 1'b0;
      m_tvalid           <= 1'b0;
      grid_rows          <= oci_pkg::GRID_ROWS_RST;
      grid_cols          <= oci_pkg::GRID_COLS_RST;
      wall_cost          <= oci_pkg::WALL_COST_RST;
      inflation_strength <= oci_pkg::STRENGTH_RST;
      free_threshold     <= oci_pkg::FREE_THR_RST;
      occupied_threshold <= oci_pkg::OCC_THR_RST;
    end else begin
      p1_valid <= nb_ok;
      p2_valid <= p1_valid;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          oci_pkg::REG_GRID_ROWS: grid_rows <= cfg_data[oci_pkg::DIMREG_W-1:0];
          oci_pkg::REG_GRID_COLS: grid_cols <= cfg_data[oci_pkg::DIMREG_W-1:0];
          oci_pkg::REG_WALL_COST: wall_cost <= cfg_data[oci_pkg::MAXCOST_W-1:0];
          oci_pkg::REG_STRENGTH:  inflation_strength <= cfg_data[oci_pkg::STRENGTH_W-1:0];
          oci_pkg::REG_FREE_THR:  free_threshold <= cfg_data[oci_pkg::THR_W-1:0];
          oci_pkg::REG_OCC_THR:   occupied_threshold <= cfg_data[oci_pkg::THR_W-1:0];
          default: ;
        endcase
      end

      // result valid: raised from the finishing step, dropped once taken
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc) begin
            if (!in_range) begin
              state <= ST_FINISH;
            end else begin
              case (s_tuser)
                oci_pkg::OP_PROCESS: begin
                  if (is_free) begin
                    state <= ST_RDWAIT;
                  end else if (is_occ) begin
                    state <= ST_SWEEP;
                    sw_dr <= '0;
                    sw_dc <= '0;
                  end else begin
                    state <= ST_FINISH;
                  end
                end
                oci_pkg::OP_WRITE: state <= ST_FINISH;
                default:           state <= ST_RDWAIT;
              endcase
            end
          end
        end
        ST_RDWAIT: state <= ST_FINISH;
        ST_SWEEP: begin
          if (sw_dc == OFF_LAST) begin
            sw_dc <= '0;
            if (sw_dr == OFF_LAST) begin
              state <= ST_DRAIN;
            end else begin
              sw_dr <= sw_dr + 1'b1;
            end
          end else begin
            sw_dc <= sw_dc + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!p1_valid && !p2_valid) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      ctr_row  <= in_row_d;
      ctr_col  <= in_col_d;
      res_oor  <= !in_range;
      res_cost <= acc_cost;
    end
    if (state == ST_RDWAIT) begin
      res_cost <= oci_pkg::OUT_W'(rd_data);
    end
    // stage 1: strength times reciprocal of the distance
    p1_addr <= nb_addr;
    p1_prod <= oci_pkg::PROD_W'(inflation_strength)
               * oci_pkg::PROD_W'(oci_pkg::recip(oci_pkg::DIST_IDX_W'(nb_dist)));
    // stage 2: capped value against the old cost
    p2_addr <= p1_addr;
    p2_val  <= COST_BITS'(p1_val);
    p2_old  <= rd_data;
    if (state == ST_FINISH && out_free) begin
      m_tdata <= res_cost;
      m_tuser <= res_oor;
    end
  end

  // a new item only enters with the write-back pipe empty
  a_pipe_empty_at_accept: assert property (@(posedge clk) disable iff (rst)
    acc |-> !p1_valid && !p2_valid)
    else $error("item accepted while inflation write-back pending");

  // inflation never writes the center cell
  a_center_untouched: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> p2_addr != ctr_addr)
    else $error("inflation addressed the occupied cell itself");

  // a result is only raised from the finishing step
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FINISH))
    else $error("result raised outside finishing step");

  // out-of-range results carry zero cost
  a_oor_zero_cost: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("out-of-range result with nonzero cost");

  // an accepted item leaves the idle state
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    acc |=> state != ST_IDLE)
    else $error("accepted item did not start processing");

endmodule
